[rtl/ptmap_pkg.sv]
package ptmap_pkg;

   localparam int TABLE_SLOTS       = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
   localparam int SLOT_W            = $clog2(TABLE_SLOTS);
   localparam int ADDR_W            = SLOT_W + IDX_W;
   localparam int MEM_DEPTH         = TABLE_SLOTS * ENTRIES_PER_TABLE;
   localparam int PFN_W             = 20;
   localparam int VA_W              = 48;
   localparam int PA_W              = 48;
   localparam int FILL_W            = PA_W + 1;
   localparam int LVL_W             = 2;

   localparam logic [31:0]      ALLOC_RESET = 32'h0010_0000;
   localparam logic [11:0]      LINK_FLAGS  = 12'h003;
   localparam logic [LVL_W-1:0] LVL_PRE     = 2'd2;
   localparam logic [LVL_W-1:0] LVL_LEAF    = 2'd3;

   typedef enum logic [1:0] {
      STAT_MAPPED    = 2'd0,
      STAT_PRESENT   = 2'd1,
      STAT_EXHAUSTED = 2'd2
   } status_type;

   typedef struct packed {
      logic       load_req;
      logic       rd;
      logic       follow;
      logic       grab;
      logic       root_clr;
      logic       clr_wr;
      logic       link_wr;
      logic       leaf_wr;
      logic       fill_wr;
      logic       respond;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic present;
      logic link_ok;
      logic pool_ok;
      logic cnt_last;
      logic lvl_leaf;
      logic lvl_pre_leaf;
      logic action;
   } sts_type;

endpackage

[rtl/ptmap_dp.sv]
module ptmap_dp
   import ptmap_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic                req_action,
   input  logic [VA_W-1:0]     req_virt_addr,
   input  logic [PA_W-1:0]     req_phys_addr,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [63:0]         rsp_leaf_entry,
   output logic [1:0]          rsp_tables_created
);

   logic [63:0]       mem [MEM_DEPTH];
   logic [63:0]       rd_data_ff;

   logic [31:0]       base_ff;
   logic [SLOT_W-1:0] pages_ff, pages_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              action_ff;
   logic [VA_W-1:0]   va_ff;
   logic [PA_W-1:0]   pa_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic [SLOT_W-1:0] new_slot_ff, new_slot_in;
   logic [1:0]        created_ff, created_in;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [63:0]       rsp_leaf_ff;
   logic [1:0]        rsp_created_ff;

   logic [IDX_W-1:0]  idx_sel;
   logic [PFN_W-1:0]  link_off;
   logic [63:0]       page_link;
   logic [63:0]       leaf_sel;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [63:0]       wr_data;

   always_comb begin
      case (level_ff)
         2'd0:    idx_sel = va_ff[47:39];
         2'd1:    idx_sel = va_ff[38:30];
         2'd2:    idx_sel = va_ff[29:21];
         default: idx_sel = va_ff[20:12];
      endcase
   end

   // link target back to a slot: page number relative to the pool base
   assign link_off  = rd_data_ff[31:12] - base_ff[31:12];
   assign page_link = {32'd0, base_ff[31:12] + PFN_W'(new_slot_ff), LINK_FLAGS};

   assign sts.present      = rd_data_ff[0];
   assign sts.link_ok      = (link_off != '0) && (link_off <= PFN_W'(pages_ff));
   assign sts.pool_ok      = (pages_ff != SLOT_W'(TABLE_SLOTS - 1));
   assign sts.cnt_last     = (cnt_ff == '1);
   assign sts.lvl_leaf     = (level_ff == LVL_LEAF);
   assign sts.lvl_pre_leaf = (level_ff == LVL_PRE);
   assign sts.action       = action_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      if (cmd.root_clr) begin
         wr_en   = 1'b1;
         wr_addr = {SLOT_W'(0), cnt_ff};
      end else if (cmd.clr_wr) begin
         wr_en   = 1'b1;
         wr_addr = {new_slot_ff, cnt_ff};
      end else if (cmd.link_wr || cmd.leaf_wr) begin
         wr_en   = 1'b1;
         wr_addr = {cur_ff, idx_sel};
         wr_data = page_link;
      end else if (cmd.fill_wr) begin
         wr_en   = 1'b1;
         wr_addr = {cur_ff, cnt_ff};
         wr_data = 64'(fill_ff) | 64'(LINK_FLAGS);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[{cur_ff, idx_sel}];
      end
   end

   always_comb begin
      pages_in    = pages_ff;
      cnt_in      = cnt_ff;
      fill_in     = fill_ff;
      level_in    = level_ff;
      cur_in      = cur_ff;
      new_slot_in = new_slot_ff;
      created_in  = created_ff;
      if (cmd.load_req) begin
         cnt_in     = '0;
         fill_in    = FILL_W'(req_phys_addr);
         level_in   = '0;
         cur_in     = '0;
         created_in = '0;
      end
      if (cmd.grab) begin
         pages_in    = pages_ff + SLOT_W'(1);
         new_slot_in = pages_ff + SLOT_W'(1);
         if (level_ff != LVL_LEAF) begin
            created_in = created_ff + 2'd1;
         end
      end
      if (cmd.follow) begin
         cur_in   = link_off[SLOT_W-1:0];
         level_in = level_ff + 2'd1;
      end
      if (cmd.link_wr) begin
         cur_in   = new_slot_ff;
         level_in = level_ff + 2'd1;
      end
      if (cmd.root_clr || cmd.clr_wr || cmd.fill_wr) begin
         cnt_in = cnt_ff + IDX_W'(1);
      end
      if (cmd.fill_wr) begin
         fill_in = fill_ff + FILL_W'(13'h1000);
      end
   end

   always_comb begin
      case (cmd.rsp_status)
         STAT_MAPPED:  leaf_sel = action_ff ? (64'(pa_ff) | 64'(LINK_FLAGS)) : page_link;
         STAT_PRESENT: leaf_sel = rd_data_ff;
         default:      leaf_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= ALLOC_RESET;
         pages_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
         pages_ff     <= pages_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= req_action;
         va_ff     <= req_virt_addr;
         pa_ff     <= req_phys_addr;
      end
      fill_ff     <= fill_in;
      level_ff    <= level_in;
      cur_ff      <= cur_in;
      new_slot_ff <= new_slot_in;
      created_ff  <= created_in;
      if (cmd.respond) begin
         rsp_status_ff  <= cmd.rsp_status;
         rsp_leaf_ff    <= leaf_sel;
         rsp_created_ff <= created_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_leaf_entry     = rsp_leaf_ff;
   assign rsp_tables_created = rsp_created_ff;

   a_grab_in_pool: assert property (@(posedge clock) disable iff (reset)
      cmd.grab |-> sts.pool_ok)
      else $error("page handed out beyond the pool");

   a_grab_bumps: assert property (@(posedge clock) disable iff (reset)
      cmd.grab |=> pages_ff == $past(pages_ff) + SLOT_W'(1))
      else $error("allocation count did not advance by one");

endmodule

[rtl/ptmap_ctrl.sv]
module ptmap_ctrl
   import ptmap_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_CLR_ROOT = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_READ     = 8'b0000_0100,
      ST_EVAL     = 8'b0000_1000,
      ST_CLEAR    = 8'b0001_0000,
      ST_LINK     = 8'b0010_0000,
      ST_LEAFW    = 8'b0100_0000,
      ST_FILL     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = STAT_MAPPED;
      unique case (state_ff)
         ST_CLR_ROOT: begin
            cmd.root_clr = 1'b1;
            if (sts.cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!sts.lvl_leaf) begin
               if (sts.present) begin
                  if (sts.link_ok) begin
                     cmd.follow = 1'b1;
                     state_in   = (sts.lvl_pre_leaf && sts.action) ? ST_FILL : ST_READ;
                  end else begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = STAT_EXHAUSTED;
                     state_in       = ST_IDLE;
                  end
               end else if (sts.pool_ok) begin
                  cmd.grab = 1'b1;
                  state_in = ST_CLEAR;
               end else begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = STAT_EXHAUSTED;
                  state_in       = ST_IDLE;
               end
            end else begin
               // single-page leaf
               if (sts.present) begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = STAT_PRESENT;
                  state_in       = ST_IDLE;
               end else if (sts.pool_ok) begin
                  cmd.grab = 1'b1;
                  state_in = ST_LEAFW;
               end else begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = STAT_EXHAUSTED;
                  state_in       = ST_IDLE;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.cnt_last) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            cmd.link_wr = 1'b1;
            state_in    = (sts.lvl_pre_leaf && sts.action) ? ST_FILL : ST_READ;
         end
         ST_LEAFW: begin
            cmd.leaf_wr = 1'b1;
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_FILL: begin
            cmd.fill_wr = 1'b1;
            if (sts.cnt_last) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR_ROOT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   a_fill_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && sts.cnt_last) |=> state_ff == ST_IDLE)
      else $error("leaf fill did not finish after the last entry");

   a_exhaust_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && !sts.present && !sts.pool_ok) |=> state_ff == ST_IDLE)
      else $error("walk went on with an empty page pool");

endmodule

[rtl/four_level_page_table_mapper_unit.sv]
// Builds four-level page tables in an internal 64-bit table store, one store word per
// cycle through a single write port and a registered read port. After reset busy stays
// high while the root table is cleared. A request is taken when start is high and busy
// is low; each walk level reads the entry, then checks it, and every table that has to
// be created is zeroed and then linked (the page is taken in the check state). A 2 MiB
// region map ends in a leaf fill of all 512 entries. A request stopped by a stray link
// or an empty pool ends early. The result is shown on the rsp_ ports for exactly one
// cycle with rsp_valid high, in the cycle after the request finishes; the receiver
// cannot stall it and must take it then.
module four_level_page_table_mapper_unit
   import ptmap_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_action,
   input  logic [VA_W-1:0]   req_virt_addr,
   input  logic [PA_W-1:0]   req_phys_addr,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [63:0]       rsp_leaf_entry,
   output logic [1:0]        rsp_tables_created
);

   cmd_type cmd;
   sts_type sts;

   ptmap_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   ptmap_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_action),
      .req_virt_addr      (req_virt_addr),
      .req_phys_addr      (req_phys_addr),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_leaf_entry     (rsp_leaf_entry),
      .rsp_tables_created (rsp_tables_created)
   );

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response strobe without a request in progress");

endmodule

[sim/ptmap_tb_pkg.sv]
package ptmap_tb_pkg;

   typedef enum logic {
      ACT_MAP_PAGE   = 1'b0,
      ACT_MAP_REGION = 1'b1
   } map_action_type;

endpackage

[sim/ptmap_checker.sv]
module ptmap_checker
   import ptmap_pkg::*;
   import ptmap_tb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            busy,
   input  logic            req_action,
   input  logic [VA_W-1:0] req_virt_addr,
   input  logic [PA_W-1:0] req_phys_addr,
   input  logic            csr_wr_en,
   input  logic [31:0]     csr_wr_data,
   input  logic            rsp_valid,
   input  logic [1:0]      rsp_status,
   input  logic [63:0]     rsp_leaf_entry,
   input  logic [1:0]      rsp_tables_created,
   output int              mismatches,
   output int              pending
);

   typedef struct {
      status_type  status;
      logic [63:0] leaf;
      logic [1:0]  created;
   } map_result_type;

   logic [63:0] table_mirror [MEM_DEPTH];
   int unsigned pages_used;
   logic [31:0] alloc_cfg;
   map_result_type expected_results [$];

   function automatic logic [31:0] pool_base();
      return alloc_cfg & 32'hFFFF_F000;
   endfunction

   // bump allocator: page n sits in slot n, 4 KiB above the previous one
   function automatic bit take_page(output int unsigned slot, output logic [31:0] addr);
      if (pages_used + 1 >= TABLE_SLOTS) begin
         return 1'b0;
      end
      pages_used++;
      slot = pages_used;
      addr = pool_base() + 32'h1000 * pages_used;
      return 1'b1;
   endfunction

   function automatic map_result_type walk_and_map(input map_action_type act,
                                                   input logic [VA_W-1:0] va,
                                                   input logic [PA_W-1:0] pa);
      map_result_type  res;
      int unsigned     cur;
      int unsigned     nxt;
      int unsigned     row;
      logic [31:0]     page_addr;
      logic [31:0]     link_off;
      logic [63:0]     entry;
      logic [63:0]     fill;
      logic [VA_W-1:0] shifted;
      res.status  = STAT_MAPPED;
      res.leaf    = '0;
      res.created = '0;
      cur = 0;
      for (int lvl = 0; lvl < 3; lvl++) begin
         shifted = va >> (39 - 9 * lvl);
         row = cur * ENTRIES_PER_TABLE + shifted[IDX_W-1:0];
         entry = table_mirror[row];
         if (entry[0]) begin
            // a link must land on a page handed out under the current base
            link_off = ({entry[31:12], 12'h000} - pool_base()) >> 12;
            if (link_off == 0 || link_off > pages_used) begin
               res.status = STAT_EXHAUSTED;
               break;
            end
            nxt = link_off;
         end else begin
            if (!take_page(nxt, page_addr)) begin
               res.status = STAT_EXHAUSTED;
               break;
            end
            for (int i = 0; i < ENTRIES_PER_TABLE; i++) begin
               table_mirror[nxt * ENTRIES_PER_TABLE + i] = '0;
            end
            table_mirror[row] = {32'h0, page_addr[31:12], LINK_FLAGS};
            res.created = res.created + 2'd1;
         end
         cur = nxt;
      end

      if (res.status == STAT_MAPPED) begin
         if (act == ACT_MAP_PAGE) begin
            row = cur * ENTRIES_PER_TABLE + va[12 +: IDX_W];
            entry = table_mirror[row];
            if (entry[0]) begin
               res.status = STAT_PRESENT;
               res.leaf   = entry;
            end else if (!take_page(nxt, page_addr)) begin
               res.status = STAT_EXHAUSTED;
            end else begin
               res.leaf = {32'h0, page_addr[31:12], LINK_FLAGS};
               table_mirror[row] = res.leaf;
            end
         end else begin
            // region fill carries past bit 47 on purpose
            fill = {{(64-PA_W){1'b0}}, pa};
            res.leaf = fill | {52'h0, LINK_FLAGS};
            for (int i = 0; i < ENTRIES_PER_TABLE; i++) begin
               table_mirror[cur * ENTRIES_PER_TABLE + i] = fill | {52'h0, LINK_FLAGS};
               fill = fill + 64'h1000;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      map_result_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES_PER_TABLE; i++) begin
            table_mirror[i] = '0;
         end
         pages_used = 0;
         alloc_cfg  = ALLOC_RESET;
         expected_results.delete();
         pending    = 0;
         mismatches = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: status %0d leaf %0h tables %0d",
                      rsp_status, rsp_leaf_entry, rsp_tables_created);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_leaf_entry !== want.leaf) begin
                  $error("leaf_entry: expected %0h, got %0h", want.leaf, rsp_leaf_entry);
                  mismatches++;
               end
               if (rsp_tables_created !== want.created) begin
                  $error("tables_created: expected %0d, got %0d",
                         want.created, rsp_tables_created);
                  mismatches++;
               end
            end
         end
         if (csr_wr_en) begin
            alloc_cfg = csr_wr_data;
         end
         if (start && !busy) begin
            expected_results.push_back(walk_and_map(map_action_type'(req_action),
                                                    req_virt_addr, req_phys_addr));
         end
         pending = expected_results.size();
      end
   end

endmodule

[sim/tb_top.sv]
module tb_top;
   import ptmap_pkg::*;
   import ptmap_tb_pkg::*;

   localparam int              WATCHDOG_LIMIT = 10000;
   // root index used while the pool base is zero; its links would resolve onto
   // neighboring slots once the base moves to 0xFFFFFFFF, so that phase avoids it
   localparam logic [VA_W-1:0] LOW_BASE_VA    = 48'h4321_0000_0000;

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   logic            req_action;
   logic [VA_W-1:0] req_virt_addr;
   logic [PA_W-1:0] req_phys_addr;
   logic            csr_wr_en;
   logic [31:0]     csr_wr_data;
   logic            rsp_valid;
   logic [1:0]      rsp_status;
   logic [63:0]     rsp_leaf_entry;
   logic [1:0]      rsp_tables_created;

   int              mismatches;
   int              pending;
   int              stall_cycles = 0;
   int              idle_pct;
   bit              ban_low_root;
   logic [VA_W-1:0] known_vas [$];

   four_level_page_table_mapper_unit uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_virt_addr      (req_virt_addr),
      .req_phys_addr      (req_phys_addr),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_leaf_entry     (rsp_leaf_entry),
      .rsp_tables_created (rsp_tables_created)
   );

   ptmap_checker chk (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_virt_addr      (req_virt_addr),
      .req_phys_addr      (req_phys_addr),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_leaf_entry     (rsp_leaf_entry),
      .rsp_tables_created (rsp_tables_created),
      .mismatches         (mismatches),
      .pending            (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [47:0] rand_word48();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[47:0];
   endfunction

   // mostly reuse walked prefixes so requests get past the upper levels
   function automatic logic [VA_W-1:0] pick_va();
      logic [VA_W-1:0] known;
      logic [VA_W-1:0] va;
      int unsigned     roll;
      do begin
         roll  = $urandom_range(0, 99);
         known = known_vas[$urandom_range(0, known_vas.size() - 1)];
         va    = rand_word48();
         if (roll < 60) begin
            va[47:21] = known[47:21];
         end else if (roll < 75) begin
            va[47:30] = known[47:30];
         end
      end while (ban_low_root && va[47:39] == LOW_BASE_VA[47:39]);
      return va;
   endfunction

   // called on a falling edge; returns on the falling edge after acceptance
   task automatic send_map(input map_action_type act, input logic [VA_W-1:0] va,
                           input logic [PA_W-1:0] pa);
      while ($urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start         = 1'b1;
      req_action    = act;
      req_virt_addr = va;
      req_phys_addr = pa;
      known_vas.push_back(va);
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain();
      while (pending != 0 || busy) begin
         start = 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic write_alloc_base(input logic [31:0] value);
      drain();
      start       = 1'b0;
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   task automatic random_phase(input int count);
      int unsigned     roll;
      logic [PA_W-1:0] pa;
      map_action_type  act;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 3) begin
            drain();
         end
         roll = $urandom_range(0, 9);
         if (roll == 0) begin
            pa = '0;
         end else if (roll == 1) begin
            pa = '1;
         end else begin
            pa = rand_word48();
         end
         act = map_action_type'($urandom_range(0, 1));
         send_map(act, pick_va(), pa);
      end
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      start         = 1'b0;
      req_action    = ACT_MAP_PAGE;
      req_virt_addr = '0;
      req_phys_addr = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      idle_pct      = 22;
      ban_low_root  = 1'b0;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      drain();

      // reset base: fresh walks, present leaves, region fills and overwrite
      send_map(ACT_MAP_PAGE,   48'h0000_0000_0000, rand_word48());
      send_map(ACT_MAP_PAGE,   48'h0000_0000_0000, rand_word48());
      send_map(ACT_MAP_PAGE,   48'h0000_0000_1000, rand_word48());
      send_map(ACT_MAP_REGION, 48'h0000_0020_0000, 48'h0000_0000_0000);
      send_map(ACT_MAP_PAGE,   48'h0000_003F_F000, rand_word48());
      send_map(ACT_MAP_REGION, 48'h0000_0020_0000, 48'hFFFF_FFFF_FFFF);
      send_map(ACT_MAP_PAGE,   48'h0000_003F_FFFF, rand_word48());
      send_map(ACT_MAP_PAGE,   48'hFFFF_FFFF_FFFF, rand_word48());
      send_map(ACT_MAP_REGION, 48'hFFFF_FFFF_F000, 48'h0000_0000_1234);
      send_map(ACT_MAP_REGION, 48'h8000_0000_0000, 48'h5555_AAAA_5000);
      send_map(ACT_MAP_PAGE,   48'h0000_4000_0000, rand_word48());

      // top base: old links go stray, new page addresses wrap past 2^32
      write_alloc_base(32'hFFFF_F000);
      send_map(ACT_MAP_PAGE,   48'h0000_0000_0000, rand_word48());
      send_map(ACT_MAP_PAGE,   48'h1234_5678_9ABC, rand_word48());
      send_map(ACT_MAP_PAGE,   48'h1234_5678_9ABC, rand_word48());

      write_alloc_base(32'h0000_0000);
      send_map(ACT_MAP_REGION, LOW_BASE_VA,        rand_word48());
      send_map(ACT_MAP_PAGE,   48'h0000_0000_0000, rand_word48());

      // low 12 bits ignored, so the first tables resolve again
      write_alloc_base(32'h0010_0FFF);
      send_map(ACT_MAP_PAGE,   48'h0000_0000_0000, rand_word48());
      send_map(ACT_MAP_PAGE,   48'h0000_0000_2000, rand_word48());

      write_alloc_base(ALLOC_RESET);
      random_phase(70);

      write_alloc_base(32'h4000_0000 + $urandom_range(0, 32'hAFFF_FFFF));
      random_phase(70);

      write_alloc_base(32'hFFFF_FFFF);
      idle_pct     = 0;
      ban_low_root = 1'b1;
      random_phase(70);
      ban_low_root = 1'b0;
      idle_pct     = 22;

      write_alloc_base(ALLOC_RESET);
      random_phase(70);

      drain();
      repeat (64) @(negedge clock);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

[files.f]
rtl/ptmap_pkg.sv
rtl/ptmap_dp.sv
rtl/ptmap_ctrl.sv
rtl/four_level_page_table_mapper_unit.sv
sim/ptmap_tb_pkg.sv
sim/ptmap_checker.sv
sim/tb_top.sv
